// ===== design/ptsp_pkg.sv =====
`timescale 1ns / 1ps

package ptsp_pkg;

  // Per-command step limits in degrees
  localparam int PAN_STEP_MAX  = 30;
  localparam int TILT_STEP_MAX = 30;

  // Pulse range for the full 180 degree sweep
  localparam int PULSE_MIN_NS = 500000;
  localparam int PULSE_MAX_NS = 2500000;
  localparam int PULSE_SAT_NS = 2500000;

  localparam int ANGLE_OFFSET = 90;
  localparam int ANGLE_SPAN   = 180;

  localparam int ANGLE_W = 8;
  localparam int DELTA_W = 9;
  localparam int TARGET_W = 10;
  localparam int PULSE_W = 22;
  localparam int IDLE_W  = 16;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  typedef logic signed [ANGLE_W-1:0]  angle_t;
  typedef logic signed [DELTA_W-1:0]  delta_t;
  typedef logic signed [TARGET_W-1:0] target_t;
  typedef logic [PULSE_W-1:0]         pulse_t;

  typedef enum logic [1:0] {
    CMD_ADJUST = 2'd0,
    CMD_HOME   = 2'd1,
    CMD_TICK   = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    REG_PAN_MIN      = 3'd0,
    REG_PAN_MAX      = 3'd1,
    REG_TILT_MIN     = 3'd2,
    REG_TILT_MAX     = 3'd3,
    REG_HOME_PAN     = 3'd4,
    REG_HOME_TILT    = 3'd5,
    REG_HOME_ENABLE  = 3'd6,
    REG_HOME_TIMEOUT = 3'd7
  } reg_idx_e;

  typedef struct packed {
    angle_t              pan_min;
    angle_t              pan_max;
    angle_t              tilt_min;
    angle_t              tilt_max;
    angle_t              home_pan;
    angle_t              home_tilt;
    logic                home_enable;
    logic [IDLE_W-1:0]   home_timeout;
  } cfg_t;

  typedef struct packed {
    logic [1:0] cmd;
    delta_t     pan_delta;
    delta_t     tilt_delta;
  } cmd_item_t;

  typedef struct packed {
    angle_t pan_deg;
    angle_t tilt_deg;
    logic   went_home;
  } res_item_t;

  typedef struct packed {
    angle_t pos;
    logic   moved;
  } axis_t;

  // Move an axis toward target: no-op when already there, else clamp to lo/hi
  function automatic axis_t set_axis(angle_t pos, target_t target, angle_t lo, angle_t hi);
    axis_t   r;
    target_t pos_x;
    target_t lo_x;
    target_t hi_x;
    pos_x   = {{(TARGET_W-ANGLE_W){pos[ANGLE_W-1]}}, pos};
    lo_x    = {{(TARGET_W-ANGLE_W){lo[ANGLE_W-1]}}, lo};
    hi_x    = {{(TARGET_W-ANGLE_W){hi[ANGLE_W-1]}}, hi};
    r.pos   = pos;
    r.moved = 1'b0;
    if (target != pos_x) begin
      r.moved = 1'b1;
      if (target < lo_x) begin
        r.pos = lo;
      end else if (target > hi_x) begin
        r.pos = hi;
      end else begin
        r.pos = target[ANGLE_W-1:0];
      end
    end
    return r;
  endfunction

  // Pulse width for one angle; only used to build the constant table
  function automatic pulse_t pulse_of(int angle);
    longint p;
    p = longint'(PULSE_MIN_NS) +
        (longint'(angle + ANGLE_OFFSET) *
         (longint'(PULSE_MAX_NS) - longint'(PULSE_MIN_NS))) / ANGLE_SPAN;
    if (p < 0) begin
      p = 0;
    end
    if (p > longint'(PULSE_SAT_NS)) begin
      p = longint'(PULSE_SAT_NS);
    end
    return PULSE_W'(p);
  endfunction

endpackage

// ===== design/ptsp_cmd_if.sv =====
`timescale 1ns / 1ps

interface ptsp_cmd_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 cmd;
  logic signed [ptsp_pkg::DELTA_W-1:0] pan_delta;
  logic signed [ptsp_pkg::DELTA_W-1:0] tilt_delta;

  modport source (output valid, cmd, pan_delta, tilt_delta, input ready);
  modport sink   (input valid, cmd, pan_delta, tilt_delta, output ready);
endinterface

// ===== design/ptsp_res_if.sv =====
`timescale 1ns / 1ps

interface ptsp_res_if;
  logic                                valid;
  logic                                ready;
  logic signed [ptsp_pkg::ANGLE_W-1:0] pan_deg_out;
  logic signed [ptsp_pkg::ANGLE_W-1:0] tilt_deg_out;
  logic [ptsp_pkg::PULSE_W-1:0]        pan_pulse_ns;
  logic [ptsp_pkg::PULSE_W-1:0]        tilt_pulse_ns;
  logic                                went_home;

  modport source (output valid, pan_deg_out, tilt_deg_out, pan_pulse_ns, tilt_pulse_ns,
                  went_home, input ready);
  modport sink   (input valid, pan_deg_out, tilt_deg_out, pan_pulse_ns, tilt_pulse_ns,
                  went_home, output ready);
endinterface

// ===== design/pan_tilt_servo_positioner_core.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Handshake            Payload
// command   in   valid/ready          cmd, pan_delta, tilt_delta
// result    out  valid/ready          pan/tilt degrees, pan/tilt pulse ns, went_home
// apb       in   psel/penable/pready  8 config registers at byte address 4*i
//
// One transaction per cycle sustained while the result is not stalled. An accepted
// command is held in the input register, then the angle update fires into the
// result register, which raises result valid.
// Pulse widths come from a 256-entry constant table indexed by the registered
// angles. Synchronous reset puts the head at center with no clearing pass.
// A stalled result holds both stages; the input register refills as the
// result drains.
module pan_tilt_servo_positioner_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ptsp_pkg::ADDR_W-1:0] paddr,
  input  logic [ptsp_pkg::DATA_W-1:0] pwdata,
  output logic [ptsp_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  ptsp_cmd_if.sink                    command,
  ptsp_res_if.source                  result
);

  ptsp_pkg::cfg_t      cfg;
  ptsp_pkg::res_item_t res;
  ptsp_pkg::pulse_t    pan_pulse;
  ptsp_pkg::pulse_t    tilt_pulse;

  // Configuration registers; the user must write them only while the datapath is quiet (not enforced here)
  ptsp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Position state, idle timer and the registered result
  ptsp_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .command   (command),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .res       (res)
  );

  // Angle to pulse width, one table read per axis off the result register
  ptsp_pulse_lut u_pan_lut (
    .angle (res.pan_deg),
    .pulse (pan_pulse)
  );

  ptsp_pulse_lut u_tilt_lut (
    .angle (res.tilt_deg),
    .pulse (tilt_pulse)
  );

  assign result.pan_deg_out   = res.pan_deg;
  assign result.tilt_deg_out  = res.tilt_deg;
  assign result.pan_pulse_ns  = pan_pulse;
  assign result.tilt_pulse_ns = tilt_pulse;
  assign result.went_home     = res.went_home;

endmodule

// ===== design/ptsp_regs.sv =====
`timescale 1ns / 1ps

module ptsp_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ptsp_pkg::ADDR_W-1:0]   paddr,
  input  logic [ptsp_pkg::DATA_W-1:0]   pwdata,
  output logic [ptsp_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output ptsp_pkg::cfg_t                cfg
);

  ptsp_pkg::reg_idx_e idx;
  logic               wr_en;

  assign idx    = ptsp_pkg::reg_idx_e'(paddr[ptsp_pkg::ADDR_W-1:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pan_min      <= -8'sd90;
      cfg.pan_max      <= 8'sd90;
      cfg.tilt_min     <= -8'sd60;
      cfg.tilt_max     <= 8'sd90;
      cfg.home_pan     <= 8'sd0;
      cfg.home_tilt    <= 8'sd0;
      cfg.home_enable  <= 1'b0;
      cfg.home_timeout <= 16'd30;
    end else if (wr_en) begin
      unique case (idx)
        ptsp_pkg::REG_PAN_MIN:      cfg.pan_min      <= pwdata[7:0];
        ptsp_pkg::REG_PAN_MAX:      cfg.pan_max      <= pwdata[7:0];
        ptsp_pkg::REG_TILT_MIN:     cfg.tilt_min     <= pwdata[7:0];
        ptsp_pkg::REG_TILT_MAX:     cfg.tilt_max     <= pwdata[7:0];
        ptsp_pkg::REG_HOME_PAN:     cfg.home_pan     <= pwdata[7:0];
        ptsp_pkg::REG_HOME_TILT:    cfg.home_tilt    <= pwdata[7:0];
        ptsp_pkg::REG_HOME_ENABLE:  cfg.home_enable  <= pwdata[0];
        ptsp_pkg::REG_HOME_TIMEOUT: cfg.home_timeout <= pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      ptsp_pkg::REG_PAN_MIN:      prdata = {24'd0, cfg.pan_min};
      ptsp_pkg::REG_PAN_MAX:      prdata = {24'd0, cfg.pan_max};
      ptsp_pkg::REG_TILT_MIN:     prdata = {24'd0, cfg.tilt_min};
      ptsp_pkg::REG_TILT_MAX:     prdata = {24'd0, cfg.tilt_max};
      ptsp_pkg::REG_HOME_PAN:     prdata = {24'd0, cfg.home_pan};
      ptsp_pkg::REG_HOME_TILT:    prdata = {24'd0, cfg.home_tilt};
      ptsp_pkg::REG_HOME_ENABLE:  prdata = {31'd0, cfg.home_enable};
      ptsp_pkg::REG_HOME_TIMEOUT: prdata = {16'd0, cfg.home_timeout};
    endcase
  end

endmodule

// ===== design/ptsp_pulse_lut.sv =====
`timescale 1ns / 1ps

module ptsp_pulse_lut (
  input  logic [ptsp_pkg::ANGLE_W-1:0] angle,
  output ptsp_pkg::pulse_t             pulse
);

  localparam int Depth = 1 << ptsp_pkg::ANGLE_W;

  ptsp_pkg::pulse_t lut [Depth];

  // Entry i holds the pulse for the two's complement angle i
  for (genvar i = 0; i < Depth; i++) begin : g_lut
    assign lut[i] = ptsp_pkg::pulse_of((i < Depth / 2) ? i : i - Depth);
  end

  assign pulse = lut[angle];

endmodule

// ===== design/ptsp_engine.sv =====
`timescale 1ns / 1ps

module ptsp_engine (
  input  logic                  clk,
  input  logic                  rst,
  input  ptsp_pkg::cfg_t        cfg,
  ptsp_cmd_if.sink              command,
  output logic                  res_valid,
  input  logic                  res_ready,
  output ptsp_pkg::res_item_t   res
);

  localparam ptsp_pkg::delta_t PanLim      = ptsp_pkg::DELTA_W'(ptsp_pkg::PAN_STEP_MAX);
  localparam ptsp_pkg::delta_t PanLimNeg   = ptsp_pkg::DELTA_W'(-ptsp_pkg::PAN_STEP_MAX);
  localparam ptsp_pkg::delta_t TiltLim     = ptsp_pkg::DELTA_W'(ptsp_pkg::TILT_STEP_MAX);
  localparam ptsp_pkg::delta_t TiltLimNeg  = ptsp_pkg::DELTA_W'(-ptsp_pkg::TILT_STEP_MAX);
  localparam int               Ext         = ptsp_pkg::TARGET_W - ptsp_pkg::ANGLE_W;
  localparam int               ExtD        = ptsp_pkg::TARGET_W - ptsp_pkg::DELTA_W;

  // Input stage
  logic                    item_valid;
  ptsp_pkg::cmd_item_t     item;
  logic                    fire;

  // Head state
  ptsp_pkg::angle_t           pan_pos,  pan_pos_next;
  ptsp_pkg::angle_t           tilt_pos, tilt_pos_next;
  logic                       activity, activity_next;
  logic [ptsp_pkg::IDLE_W-1:0] idle_secs, idle_secs_next;
  logic                       went;

  ptsp_pkg::angle_t   eh_pan, eh_tilt;
  ptsp_pkg::delta_t   dp, dt;
  ptsp_pkg::target_t  tgt_pan, tgt_tilt;
  ptsp_pkg::axis_t    adj_pan, adj_tilt, home_pan_r, home_tilt_r;
  logic [ptsp_pkg::IDLE_W-1:0] idle_inc;

  assign fire          = item_valid && (!res_valid || res_ready);
  assign command.ready = !item_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (command.ready) begin
      item_valid <= command.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (command.valid && command.ready) begin
      item.cmd        <= command.cmd;
      item.pan_delta  <= command.pan_delta;
      item.tilt_delta <= command.tilt_delta;
    end
  end

  always_comb begin
    // Home angles outside the limits fall back to center
    eh_pan  = (cfg.home_pan < cfg.pan_min || cfg.home_pan > cfg.pan_max) ?
              '0 : cfg.home_pan;
    eh_tilt = (cfg.home_tilt < cfg.tilt_min || cfg.home_tilt > cfg.tilt_max) ?
              '0 : cfg.home_tilt;

    dp = (item.pan_delta < PanLimNeg) ? PanLimNeg :
         (item.pan_delta > PanLim) ? PanLim : item.pan_delta;
    dt = (item.tilt_delta < TiltLimNeg) ? TiltLimNeg :
         (item.tilt_delta > TiltLim) ? TiltLim : item.tilt_delta;

    // Positive pan delta turns right, which lowers the pan angle
    tgt_pan  = {{Ext{pan_pos[ptsp_pkg::ANGLE_W-1]}}, pan_pos} -
               {{ExtD{dp[ptsp_pkg::DELTA_W-1]}}, dp};
    tgt_tilt = {{Ext{tilt_pos[ptsp_pkg::ANGLE_W-1]}}, tilt_pos} +
               {{ExtD{dt[ptsp_pkg::DELTA_W-1]}}, dt};

    adj_pan     = ptsp_pkg::set_axis(pan_pos, tgt_pan, cfg.pan_min, cfg.pan_max);
    adj_tilt    = ptsp_pkg::set_axis(tilt_pos, tgt_tilt, cfg.tilt_min, cfg.tilt_max);
    home_pan_r  = ptsp_pkg::set_axis(pan_pos, {{Ext{eh_pan[ptsp_pkg::ANGLE_W-1]}}, eh_pan},
                                     cfg.pan_min, cfg.pan_max);
    home_tilt_r = ptsp_pkg::set_axis(tilt_pos, {{Ext{eh_tilt[ptsp_pkg::ANGLE_W-1]}}, eh_tilt},
                                     cfg.tilt_min, cfg.tilt_max);

    idle_inc = (idle_secs == '1) ? idle_secs : idle_secs + 1'b1;

    pan_pos_next   = pan_pos;
    tilt_pos_next  = tilt_pos;
    activity_next  = activity;
    idle_secs_next = idle_secs;
    went           = 1'b0;

    case (item.cmd)
      ptsp_pkg::CMD_ADJUST: begin
        pan_pos_next  = adj_pan.pos;
        tilt_pos_next = adj_tilt.pos;
        activity_next = activity || adj_pan.moved || adj_tilt.moved;
      end
      ptsp_pkg::CMD_HOME: begin
        pan_pos_next  = home_pan_r.pos;
        tilt_pos_next = home_tilt_r.pos;
        activity_next = 1'b1;
        went          = 1'b1;
      end
      ptsp_pkg::CMD_TICK: begin
        if (!cfg.home_enable) begin
          idle_secs_next = '0;
        end else if (activity) begin
          activity_next  = 1'b0;
          idle_secs_next = '0;
        end else if (idle_inc >= cfg.home_timeout) begin
          idle_secs_next = '0;
          if (pan_pos != eh_pan || tilt_pos != eh_tilt) begin
            pan_pos_next  = home_pan_r.pos;
            tilt_pos_next = home_tilt_r.pos;
            activity_next = 1'b1;
            went          = 1'b1;
          end
        end else begin
          idle_secs_next = idle_inc;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pan_pos   <= '0;
      tilt_pos  <= '0;
      activity  <= 1'b1;
      idle_secs <= '0;
      res_valid <= 1'b0;
    end else begin
      if (fire) begin
        pan_pos   <= pan_pos_next;
        tilt_pos  <= tilt_pos_next;
        activity  <= activity_next;
        idle_secs <= idle_secs_next;
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res.pan_deg   <= pan_pos_next;
      res.tilt_deg  <= tilt_pos_next;
      res.went_home <= went;
    end
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;

  // Command code the block leaves unused
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int IDLE_SAT = 65535;
  localparam int RANDOM_SETUPS = 8;
  localparam int ITEMS_PER_SETUP = 98;

  typedef struct {
    ptsp_pkg::angle_t pan_min;
    ptsp_pkg::angle_t pan_max;
    ptsp_pkg::angle_t tilt_min;
    ptsp_pkg::angle_t tilt_max;
    ptsp_pkg::angle_t home_pan;
    ptsp_pkg::angle_t home_tilt;
    logic             home_enable;
    logic [15:0]      home_timeout;
  } rig_setup_t;

  typedef struct {
    ptsp_pkg::angle_t pan;
    ptsp_pkg::angle_t tilt;
    ptsp_pkg::pulse_t pan_ns;
    ptsp_pkg::pulse_t tilt_ns;
    logic             homed;
  } pose_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ptsp_pkg::ADDR_W-1:0] paddr;
  logic [ptsp_pkg::DATA_W-1:0] pwdata;
  logic [ptsp_pkg::DATA_W-1:0] prdata;
  logic pready;

  ptsp_cmd_if cmd_ch ();
  ptsp_res_if res_ch ();

  pan_tilt_servo_positioner_core i_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .command (cmd_ch),
    .result  (res_ch)
  );

  // Shadow of the head: register copy and position state
  rig_setup_t       setup;
  ptsp_pkg::angle_t pan_pos;
  ptsp_pkg::angle_t tilt_pos;
  bit               recent_motion;
  int unsigned      idle_secs;

  pose_t expected_poses[$];

  bit idle_on;
  int errors;
  int commands_sent;
  int poses_checked;
  int homing_moves;
  int setups_run;

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  // Angle plus 90, scaled over the 180 degree sweep, truncated toward zero
  function automatic ptsp_pkg::pulse_t servo_pulse(ptsp_pkg::angle_t a);
    longint w;
    w = longint'(ptsp_pkg::PULSE_MIN_NS) +
        (longint'(int'(a) + ptsp_pkg::ANGLE_OFFSET) *
         longint'(ptsp_pkg::PULSE_MAX_NS - ptsp_pkg::PULSE_MIN_NS)) /
        longint'(ptsp_pkg::ANGLE_SPAN);
    if (w < 0) begin
      w = 0;
    end
    if (w > longint'(ptsp_pkg::PULSE_SAT_NS)) begin
      w = longint'(ptsp_pkg::PULSE_SAT_NS);
    end
    return ptsp_pkg::pulse_t'(w);
  endfunction

  function automatic int clip_step(int d, int lim);
    if (d < -lim) begin
      return -lim;
    end
    if (d > lim) begin
      return lim;
    end
    return d;
  endfunction

  // No change when already on target, else clamp min first, then max
  task automatic aim_axis(inout ptsp_pkg::angle_t pos, input int target,
                          input ptsp_pkg::angle_t lo, input ptsp_pkg::angle_t hi);
    if (target != int'(pos)) begin
      if (target < int'(lo)) begin
        pos = lo;
      end else if (target > int'(hi)) begin
        pos = hi;
      end else begin
        pos = ptsp_pkg::angle_t'(target);
      end
      recent_motion = 1'b1;
    end
  endtask

  // Home angle outside the current limits falls back to center
  function automatic int home_pan_target();
    if (int'(setup.home_pan) < int'(setup.pan_min) ||
        int'(setup.home_pan) > int'(setup.pan_max)) begin
      return 0;
    end
    return int'(setup.home_pan);
  endfunction

  function automatic int home_tilt_target();
    if (int'(setup.home_tilt) < int'(setup.tilt_min) ||
        int'(setup.home_tilt) > int'(setup.tilt_max)) begin
      return 0;
    end
    return int'(setup.home_tilt);
  endfunction

  task automatic return_home();
    aim_axis(pan_pos, home_pan_target(), setup.pan_min, setup.pan_max);
    aim_axis(tilt_pos, home_tilt_target(), setup.tilt_min, setup.tilt_max);
    recent_motion = 1'b1;
  endtask

  task automatic reset_shadow();
    setup.pan_min      = -8'sd90;
    setup.pan_max      = 8'sd90;
    setup.tilt_min     = -8'sd60;
    setup.tilt_max     = 8'sd90;
    setup.home_pan     = '0;
    setup.home_tilt    = '0;
    setup.home_enable  = 1'b0;
    setup.home_timeout = 16'd30;
    pan_pos       = '0;
    tilt_pos      = '0;
    recent_motion = 1'b1;
    idle_secs     = 0;
  endtask

  // Advance the shadow head by one command and queue the pose it must report
  task automatic predict_pose(logic [1:0] code, ptsp_pkg::delta_t dp, ptsp_pkg::delta_t dt);
    pose_t p;
    logic  homed;
    int    step_pan;
    int    step_tilt;
    homed = 1'b0;
    case (code)
      ptsp_pkg::CMD_ADJUST: begin
        step_pan  = clip_step(int'(dp), ptsp_pkg::PAN_STEP_MAX);
        step_tilt = clip_step(int'(dt), ptsp_pkg::TILT_STEP_MAX);
        aim_axis(pan_pos, int'(pan_pos) - step_pan, setup.pan_min, setup.pan_max);
        aim_axis(tilt_pos, int'(tilt_pos) + step_tilt, setup.tilt_min, setup.tilt_max);
      end
      ptsp_pkg::CMD_HOME: begin
        return_home();
        homed = 1'b1;
      end
      ptsp_pkg::CMD_TICK: begin
        if (!setup.home_enable) begin
          idle_secs = 0;
        end else if (recent_motion) begin
          recent_motion = 1'b0;
          idle_secs = 0;
        end else begin
          if (idle_secs < IDLE_SAT) begin
            idle_secs++;
          end
          if (idle_secs >= int'(setup.home_timeout)) begin
            idle_secs = 0;
            if (int'(pan_pos) != home_pan_target() ||
                int'(tilt_pos) != home_tilt_target()) begin
              return_home();
              homed = 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase
    p.pan     = pan_pos;
    p.tilt    = tilt_pos;
    p.pan_ns  = servo_pulse(pan_pos);
    p.tilt_ns = servo_pulse(tilt_pos);
    p.homed   = homed;
    if (homed) begin
      homing_moves++;
    end
    expected_poses.push_back(p);
  endtask

  function automatic int unsigned draw_wait();
    return idle_on ? $urandom_range(0, 9) : 0;
  endfunction

  // One command transaction; valid stays up so back-to-back items need no dip
  task automatic send_command(logic [1:0] code, ptsp_pkg::delta_t dp, ptsp_pkg::delta_t dt);
    int unsigned gap;
    gap = draw_wait();
    if (gap != 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid      <= 1'b1;
    cmd_ch.cmd        <= code;
    cmd_ch.pan_delta  <= dp;
    cmd_ch.tilt_delta <= dt;
    do begin
      @(posedge clk);
    end while (!cmd_ch.ready);
    predict_pose(code, dp, dt);
    commands_sent++;
  endtask

  task automatic adjust(int dp, int dt);
    send_command(ptsp_pkg::CMD_ADJUST, ptsp_pkg::delta_t'(dp), ptsp_pkg::delta_t'(dt));
  endtask

  task automatic plain(logic [1:0] code);
    send_command(code, ptsp_pkg::delta_t'($urandom), ptsp_pkg::delta_t'($urandom));
  endtask

  // Drop valid, wait out every pending pose, then the pipeline depth
  task automatic settle();
    cmd_ch.valid <= 1'b0;
    while (expected_poses.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  // Setup and access phase, then an idle phase with psel low before the next write
  task automatic cfg_write(ptsp_pkg::reg_idx_e idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ptsp_pkg::ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(posedge clk);
    end while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    case (idx)
      ptsp_pkg::REG_PAN_MIN:      setup.pan_min      = ptsp_pkg::angle_t'(value[7:0]);
      ptsp_pkg::REG_PAN_MAX:      setup.pan_max      = ptsp_pkg::angle_t'(value[7:0]);
      ptsp_pkg::REG_TILT_MIN:     setup.tilt_min     = ptsp_pkg::angle_t'(value[7:0]);
      ptsp_pkg::REG_TILT_MAX:     setup.tilt_max     = ptsp_pkg::angle_t'(value[7:0]);
      ptsp_pkg::REG_HOME_PAN:     setup.home_pan     = ptsp_pkg::angle_t'(value[7:0]);
      ptsp_pkg::REG_HOME_TILT:    setup.home_tilt    = ptsp_pkg::angle_t'(value[7:0]);
      ptsp_pkg::REG_HOME_ENABLE:  setup.home_enable  = value[0];
      ptsp_pkg::REG_HOME_TIMEOUT: setup.home_timeout = value[15:0];
      default: begin
      end
    endcase
  endtask

  task automatic load_setup(int pmin, int pmax, int tmin, int tmax, int hp, int ht,
                            logic en, logic [15:0] tmo);
    cfg_write(ptsp_pkg::REG_PAN_MIN, 32'(pmin));
    cfg_write(ptsp_pkg::REG_PAN_MAX, 32'(pmax));
    cfg_write(ptsp_pkg::REG_TILT_MIN, 32'(tmin));
    cfg_write(ptsp_pkg::REG_TILT_MAX, 32'(tmax));
    cfg_write(ptsp_pkg::REG_HOME_PAN, 32'(hp));
    cfg_write(ptsp_pkg::REG_HOME_TILT, 32'(ht));
    cfg_write(ptsp_pkg::REG_HOME_ENABLE, {31'($urandom), en});
    cfg_write(ptsp_pkg::REG_HOME_TIMEOUT, {16'($urandom), tmo});
    setups_run++;
  endtask

  // Compare one result transaction against the oldest pending pose
  task automatic check_pose();
    pose_t p;
    if (expected_poses.size() == 0) begin
      $error("result transaction with no pending pose");
      errors++;
      return;
    end
    p = expected_poses.pop_front();
    poses_checked++;
    if (res_ch.pan_deg_out !== p.pan) begin
      $error("pan_deg_out: expected %0d, got %0d", p.pan, res_ch.pan_deg_out);
      errors++;
    end
    if (res_ch.tilt_deg_out !== p.tilt) begin
      $error("tilt_deg_out: expected %0d, got %0d", p.tilt, res_ch.tilt_deg_out);
      errors++;
    end
    if (res_ch.pan_pulse_ns !== p.pan_ns) begin
      $error("pan_pulse_ns: expected %0d, got %0d", p.pan_ns, res_ch.pan_pulse_ns);
      errors++;
    end
    if (res_ch.tilt_pulse_ns !== p.tilt_ns) begin
      $error("tilt_pulse_ns: expected %0d, got %0d", p.tilt_ns, res_ch.tilt_pulse_ns);
      errors++;
    end
    if (res_ch.went_home !== p.homed) begin
      $error("went_home: expected %0d, got %0d", p.homed, res_ch.went_home);
      errors++;
    end
  endtask

  // Result sink: random stall after each transaction while idle_on is set, counted in cycles
  initial begin
    int unsigned hold;
    res_ch.ready <= 1'b0;
    hold = 3;
    forever begin
      @(posedge clk);
      if (!rst && res_ch.valid && res_ch.ready) begin
        check_pose();
        hold = draw_wait();
        if (hold != 0) begin
          res_ch.ready <= 1'b0;
        end
      end else if (!res_ch.ready) begin
        if (hold > 1) begin
          hold--;
        end else begin
          res_ch.ready <= 1'b1;
        end
      end
    end
  end

  // Step clamps, axis limits, home, ticks and the unused code at reset settings
  task automatic test_step_clamps();
    adjust(0, 0);
    adjust(255, -256);
    adjust(-256, 255);
    adjust(30, -30);
    adjust(31, -31);
    adjust(-30, 30);
    adjust(180, -180);
    adjust(-180, 180);
    repeat (5) adjust(-30, -30);
    adjust(-1, -1);
    send_command(ptsp_pkg::CMD_HOME, '0, '0);
    send_command(ptsp_pkg::CMD_HOME, '0, '0);
    plain(CMD_UNUSED);
    plain(ptsp_pkg::CMD_TICK);
    plain(ptsp_pkg::CMD_TICK);
    settle();
  endtask

  // Widest register values (pulse saturation), bad home angles, crossed limits
  task automatic test_odd_limits();
    load_setup(-128, 127, -128, 127, 127, -128, 1'b0, 16'hFFFF);
    repeat (3) adjust(-30, 30);
    send_command(ptsp_pkg::CMD_HOME, '0, '0);
    repeat (3) adjust(30, -30);
    settle();
    load_setup(40, -40, 50, -50, 100, -100, 1'b0, 16'd30);
    send_command(ptsp_pkg::CMD_HOME, '0, '0);
    adjust(10, 10);
    adjust(-100, -100);
    adjust(0, 0);
    settle();
  endtask

  // Idle timeout: zero, short, and the largest value, then with auto return disabled
  task automatic test_auto_return();
    load_setup(-90, 90, -90, 90, 20, -10, 1'b1, 16'd0);
    repeat (4) plain(ptsp_pkg::CMD_TICK);
    adjust(20, 20);
    repeat (3) plain(ptsp_pkg::CMD_TICK);
    settle();
    cfg_write(ptsp_pkg::REG_HOME_TIMEOUT, 32'd3);
    adjust(-15, 15);
    repeat (6) plain(ptsp_pkg::CMD_TICK);
    adjust(0, 0);
    plain(ptsp_pkg::CMD_TICK);
    settle();
    cfg_write(ptsp_pkg::REG_HOME_TIMEOUT, 32'hFFFF);
    adjust(5, 5);
    repeat (3) plain(ptsp_pkg::CMD_TICK);
    settle();
    cfg_write(ptsp_pkg::REG_HOME_ENABLE, 32'd0);
    repeat (2) plain(ptsp_pkg::CMD_TICK);
    settle();
  endtask

  function automatic int some_angle();
    return int'($urandom_range(0, 180)) - ptsp_pkg::ANGLE_OFFSET;
  endfunction

  task automatic random_setup(int phase);
    int a;
    int b;
    int c;
    int d;
    if (phase == 0) begin
      load_setup(-90, 90, -90, 90, -90, 90, 1'b1, 16'd0);
    end else if (phase % 4 == 3) begin
      load_setup(int'($urandom), int'($urandom), int'($urandom), int'($urandom),
                 int'($urandom), int'($urandom), 1'($urandom),
                 ($urandom_range(0, 1) != 0) ? 16'($urandom) : 16'($urandom_range(0, 5)));
    end else begin
      a = some_angle();
      b = some_angle();
      c = some_angle();
      d = some_angle();
      load_setup((a < b) ? a : b, (a < b) ? b : a, (c < d) ? c : d, (c < d) ? d : c,
                 some_angle() / 2, some_angle() / 2, $urandom_range(0, 4) != 0,
                 16'($urandom_range(0, 6)));
    end
  endtask

  // Mostly moves and tick bursts so idle returns fire often
  task automatic test_random_traffic();
    int n;
    int r;
    int burst;
    for (int phase = 0; phase < RANDOM_SETUPS; phase++) begin
      idle_on = (phase % 3 != 1);
      random_setup(phase);
      n = 0;
      while (n < ITEMS_PER_SETUP) begin
        r = $urandom_range(0, 99);
        if (r < 30) begin
          adjust(int'($urandom_range(0, 80)) - 40, int'($urandom_range(0, 80)) - 40);
          n++;
        end else if (r < 50) begin
          send_command(ptsp_pkg::CMD_ADJUST, ptsp_pkg::delta_t'($urandom),
                       ptsp_pkg::delta_t'($urandom));
          n++;
        end else if (r < 55) begin
          adjust(0, 0);
          n++;
        end else if (r < 63) begin
          plain(ptsp_pkg::CMD_HOME);
          n++;
        end else if (r < 95) begin
          burst = $urandom_range(1, 8);
          repeat (burst) plain(ptsp_pkg::CMD_TICK);
          n += burst;
        end else begin
          plain(CMD_UNUSED);
          n++;
        end
      end
      settle();
    end
  endtask

  initial begin
    rst               <= 1'b1;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    cmd_ch.valid      <= 1'b0;
    cmd_ch.cmd        <= ptsp_pkg::CMD_ADJUST;
    cmd_ch.pan_delta  <= '0;
    cmd_ch.tilt_delta <= '0;
    errors        = 0;
    commands_sent = 0;
    poses_checked = 0;
    homing_moves  = 0;
    setups_run    = 0;
    idle_on       = 1'b1;
    reset_shadow();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_step_clamps();
    test_odd_limits();
    test_auto_return();
    test_random_traffic();

    settle();
    repeat (6) @(posedge clk);
    if (expected_poses.size() != 0) begin
      $error("%0d poses never reported", expected_poses.size());
      errors++;
    end
    $display("Sent %0d commands over %0d register setups; %0d poses checked",
             commands_sent, setups_run, poses_checked);
    $display("%0d of them went home, by command or by idle timeout", homing_moves);
    if (errors == 0) begin
      $display("pan_tilt_servo_positioner_core verification clean");
    end else begin
      $display("pan_tilt_servo_positioner_core verification failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #(10_000_000);
    $display("pan_tilt_servo_positioner_core verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/ptsp_pkg.sv
design/ptsp_cmd_if.sv
design/ptsp_res_if.sv
design/ptsp_regs.sv
design/ptsp_pulse_lut.sv
design/ptsp_engine.sv
design/pan_tilt_servo_positioner_core.sv
test/tb.sv
